// ===== src/hnu_pkg.sv =====
// shared types, constants and register codes of the heightmap normal/uv stream
`timescale 1ns / 1ps
`default_nettype none

package hnu_pkg;

  // configuration register layout
  localparam int unsigned GRID_SIZE_W   = 11;
  localparam int unsigned EXTENT_W      = 31;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam logic        REG_GRID_SIZE = 1'b0;
  localparam logic        REG_EXTENT    = 1'b1;
  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 11'd257;
  localparam logic [EXTENT_W-1:0]    EXTENT_RST    = 31'd131072;

  // default row store depth
  localparam int unsigned MAX_GRID_DEF = 1024;

  // sequencing counts
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned IDX_W     = 3;
  localparam logic [STEP_W-1:0] MUL_LAST  = 5'd6;
  localparam logic [STEP_W-1:0] SQ_LAST   = 5'd3;
  localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd15;
  localparam logic [IDX_W-1:0]  IDX_NRM_X = 3'd0;
  localparam logic [IDX_W-1:0]  IDX_TEX_U = 3'd3;
  localparam logic [IDX_W-1:0]  IDX_TEX_V = 3'd4;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_RD0, OP_RD1, OP_RD2, OP_RD3, OP_DIFF, OP_MUL,
    OP_MAXC, OP_NORM, OP_SQ, OP_SQRT, OP_DSET, OP_DITR, OP_DSTO, OP_OUT
  } hnu_op_e;

  typedef struct packed {
    hnu_op_e           op;
    logic [STEP_W-1:0] step;
    logic [IDX_W-1:0]  idx;
  } hnu_cmd_t;

  typedef struct packed {
    logic interior;
    logic degen;
    logic norm_done;
  } hnu_sts_t;

  typedef struct packed {
    logic               frame_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } hnu_in_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               degenerate;
    logic               last_of_grid;
  } hnu_out_t;

endpackage

`default_nettype wire

// ===== src/hnu_ctrl.sv =====
// sequencer of the heightmap normal/uv stream
`timescale 1ns / 1ps
`default_nettype none

module hnu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire hnu_pkg::hnu_sts_t sts_i,
  output hnu_pkg::hnu_cmd_t      cmd_o
);
  import hnu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_RD3  = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_MAXC = 4'd7;
  localparam logic [3:0] S_NORM = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_SQRT = 4'd10;
  localparam logic [3:0] S_DSET = 4'd11;
  localparam logic [3:0] S_DITR = 4'd12;
  localparam logic [3:0] S_DSTO = 4'd13;
  localparam logic [3:0] S_OUTW = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              ovld_q, ovld_d;
  logic              slot_free;

  assign slot_free   = !ovld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  // next state and command
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    idx_d     = idx_q;
    ovld_d    = ovld_q && !out_ready_i;
    cmd_o.op   = OP_NOP;
    cmd_o.step = step_q;
    cmd_o.idx  = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_RD0;
        end
      end
      S_RD0: begin
        cmd_o.op = OP_RD0;
        state_d  = S_RD1;
      end
      S_RD1: begin
        cmd_o.op = OP_RD1;
        state_d  = S_RD2;
      end
      S_RD2: begin
        cmd_o.op = OP_RD2;
        state_d  = S_RD3;
      end
      S_RD3: begin
        cmd_o.op = OP_RD3;
        state_d  = sts_i.interior ? S_DIFF : S_IDLE;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        step_d   = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        if (step_q == MUL_LAST) begin
          state_d = S_MAXC;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_MAXC: begin
        cmd_o.op = OP_MAXC;
        state_d  = S_NORM;
      end
      S_NORM: begin
        if (sts_i.degen) begin
          idx_d   = IDX_TEX_U;
          state_d = S_DSET;
        end else if (sts_i.norm_done) begin
          step_d  = '0;
          state_d = S_SQ;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        if (step_q == SQ_LAST) begin
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (step_q == SQRT_LAST) begin
          idx_d   = IDX_NRM_X;
          state_d = S_DSET;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DSET: begin
        cmd_o.op = OP_DSET;
        step_d   = '0;
        state_d  = S_DITR;
      end
      S_DITR: begin
        cmd_o.op = OP_DITR;
        if (step_q == DIV_LAST) begin
          state_d = S_DSTO;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DSTO: begin
        cmd_o.op = OP_DSTO;
        if (idx_q == IDX_TEX_V) begin
          state_d = S_OUTW;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DSET;
        end
      end
      S_OUTW: begin
        if (slot_free) begin
          cmd_o.op = OP_OUT;
          ovld_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/hnu_datapath.sv =====
// row stores, shared multiplier, square root and divider of the normal/uv stream
`timescale 1ns / 1ps
`default_nettype none

module hnu_datapath #(
  parameter int unsigned MAX_GRID = hnu_pkg::MAX_GRID_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire hnu_pkg::hnu_cmd_t                 cmd_i,
  output hnu_pkg::hnu_sts_t                      sts_o,
  input  wire hnu_pkg::hnu_in_t                  in_item_i,
  input  wire logic [hnu_pkg::GRID_SIZE_W-1:0]   grid_size_i,
  input  wire logic [hnu_pkg::EXTENT_W-1:0]      extent_i,
  output hnu_pkg::hnu_out_t                      out_item_o
);
  import hnu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_GRID);
  localparam int unsigned NW = (GRID_SIZE_W > CW + 1) ? GRID_SIZE_W : CW + 1;

  typedef logic [2:0][31:0] vtx_t;

  // halve all magnitudes of a difference vector component when needed
  function automatic logic [31:0] shrink1(logic [32:0] v, logic big);
    logic [32:0] mag;
    logic [32:0] half;
    logic [32:0] res;
    mag  = v[32] ? (33'd0 - v) : v;
    half = mag >> 1;
    res  = v[32] ? (33'd0 - half) : half;
    return big ? res[31:0] : v[31:0];
  endfunction

  // grid position state
  logic [CW-1:0] col_q, row_q;
  logic          sel_q;

  // item registers
  vtx_t          inp_q, lft_q, rgt_q, up_q, ctr_q;
  logic [CW-1:0] c_q;
  logic          selc_q, int_q, last_q;

  // load decode
  logic [CW-1:0] c_cur, r_cur, col_d, row_d;
  logic          s_cur, sel_d, int_d, last_d;
  logic [NW-1:0] gs, n, c_e, r_e;

  always_comb begin
    c_cur = in_item_i.frame_start ? '0 : col_q;
    r_cur = in_item_i.frame_start ? '0 : row_q;
    s_cur = in_item_i.frame_start ? 1'b0 : sel_q;
    gs    = NW'(grid_size_i);
    if (gs < NW'(3)) begin
      n = NW'(3);
    end else if (gs > NW'(MAX_GRID)) begin
      n = NW'(MAX_GRID);
    end else begin
      n = gs;
    end
    c_e    = NW'(c_cur);
    r_e    = NW'(r_cur);
    int_d  = (r_e >= NW'(2)) && (r_e <= n - NW'(1)) &&
             (c_e >= NW'(1)) && (c_e <= n - NW'(2));
    last_d = (r_e == n - NW'(1)) && (c_e == n - NW'(2));
    if (c_e + NW'(1) >= n) begin
      col_d = '0;
      sel_d = ~s_cur;
      row_d = (r_e + NW'(1) >= n) ? '0 : r_cur + CW'(1);
    end else begin
      col_d = c_cur + CW'(1);
      sel_d = s_cur;
      row_d = (r_e >= n) ? '0 : r_cur;
    end
  end

  // counters advance as each item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sel_q <= 1'b0;
    end else if (cmd_i.op == OP_LOAD) begin
      col_q <= col_d;
      row_q <= row_d;
      sel_q <= sel_d;
    end
  end

  // row stores, one read port each with registered data
  vtx_t          mem_a [MAX_GRID];
  vtx_t          mem_b [MAX_GRID];
  vtx_t          rd_a_q, rd_b_q, new_rd, old_rd;
  logic [CW-1:0] addr_new, addr_a, addr_b;
  logic          we_a, we_b;

  always_comb begin
    case (cmd_i.op)
      OP_RD0:  addr_new = c_q - CW'(1);
      OP_RD1:  addr_new = c_q + CW'(1);
      default: addr_new = c_q;
    endcase
  end

  assign addr_a = selc_q ? addr_new : c_q;
  assign addr_b = selc_q ? c_q : addr_new;
  assign we_a   = (cmd_i.op == OP_RD3) && !selc_q;
  assign we_b   = (cmd_i.op == OP_RD3) && selc_q;
  assign new_rd = selc_q ? rd_a_q : rd_b_q;
  assign old_rd = selc_q ? rd_b_q : rd_a_q;

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_a[addr_a];
    if (we_a) begin
      mem_a[c_q] <= inp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_b_q <= mem_b[addr_b];
    if (we_b) begin
      mem_b[c_q] <= inp_q;
    end
  end

  // difference vectors with range reduction
  logic [2:0][32:0] da, db;
  logic [2:0][31:0] a_d, b_d;
  logic             big_a, big_b;

  always_comb begin
    big_a = 1'b0;
    big_b = 1'b0;
    for (int k = 0; k < 3; k++) begin
      da[k] = {rgt_q[k][31], rgt_q[k]} - {lft_q[k][31], lft_q[k]};
      db[k] = {up_q[k][31], up_q[k]} - {inp_q[k][31], inp_q[k]};
      if ((da[k][32] ? (33'd0 - da[k]) : da[k]) >= 33'h080000000) big_a = 1'b1;
      if ((db[k][32] ? (33'd0 - db[k]) : db[k]) >= 33'h080000000) big_b = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      a_d[k] = shrink1(da[k], big_a);
      b_d[k] = shrink1(db[k], big_b);
    end
  end

  // shared signed multiplier, registered product
  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic [63:0]        m_q [3];
  logic [2:0]         neg_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q, hold_q, cr;
  logic [1:0]         ck;

  always_comb begin
    mul_a = a_q[0];
    mul_b = b_q[0];
    if (cmd_i.op == OP_SQ) begin
      case (cmd_i.step[1:0])
        2'd0: begin
          mul_a = $signed({2'b00, m_q[0][29:0]});
          mul_b = $signed({2'b00, m_q[0][29:0]});
        end
        2'd1: begin
          mul_a = $signed({2'b00, m_q[1][29:0]});
          mul_b = $signed({2'b00, m_q[1][29:0]});
        end
        default: begin
          mul_a = $signed({2'b00, m_q[2][29:0]});
          mul_b = $signed({2'b00, m_q[2][29:0]});
        end
      endcase
    end else begin
      case (cmd_i.step[2:0])
        3'd0: begin mul_a = a_q[1]; mul_b = b_q[2]; end
        3'd1: begin mul_a = a_q[2]; mul_b = b_q[1]; end
        3'd2: begin mul_a = a_q[2]; mul_b = b_q[0]; end
        3'd3: begin mul_a = a_q[0]; mul_b = b_q[2]; end
        3'd4: begin mul_a = a_q[0]; mul_b = b_q[1]; end
        3'd5: begin mul_a = a_q[1]; mul_b = b_q[0]; end
        default: begin mul_a = a_q[0]; mul_b = b_q[0]; end
      endcase
    end
  end

  assign cr = hold_q - prod_q;
  assign ck = cmd_i.step[2:1] - 2'd1;

  // largest magnitude and normalization steps
  logic [63:0] mx_q, mx01;
  logic        ge38, ge30, lt21, lt29;

  assign mx01 = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
  assign ge38 = |mx_q[63:38];
  assign ge30 = |mx_q[63:30];
  assign lt21 = ~|mx_q[63:21];
  assign lt29 = ~|mx_q[63:29];

  // bitwise square root
  logic [63:0] sv_q, sr_q, sb_q, trial;
  assign trial = sr_q + sb_q;

  // shared divider, quotient below 2^16 after saturation test
  logic [30:0]        dv_q, ev, len, dv_d;
  logic [30:0]        rem_q;
  logic [15:0]        qr_q, qres, nmag;
  logic               sat_q, zro_q, zro_d;
  logic [48:0]        num;
  logic signed [31:0] tp;
  logic signed [33:0] tt;
  logic [31:0]        dsh;
  logic               dge;
  logic [15:0]        res_q [5];

  assign ev  = (extent_i == '0) ? 31'd1 : extent_i;
  assign len = sr_q[30:0];
  assign tp  = (cmd_i.idx == IDX_TEX_U) ? $signed(ctr_q[0]) : $signed(ctr_q[2]);
  assign tt  = $signed({tp[31], tp, 1'b0}) + $signed({3'b000, ev});

  always_comb begin
    if (cmd_i.idx < IDX_TEX_U) begin
      dv_d  = len;
      zro_d = 1'b0;
      case (cmd_i.idx[1:0])
        2'd0:    num = {4'd0, m_q[0][29:0], 15'd0} + 49'(len >> 1);
        2'd1:    num = {4'd0, m_q[1][29:0], 15'd0} + 49'(len >> 1);
        default: num = {4'd0, m_q[2][29:0], 15'd0} + 49'(len >> 1);
      endcase
    end else begin
      dv_d  = ev;
      zro_d = tt[33] || (tt == '0);
      num   = {1'b0, tt[32:0], 15'd0} + 49'(ev >> 1);
    end
  end

  assign dsh  = {rem_q, qr_q[15]};
  assign dge  = dsh >= {1'b0, dv_q};
  assign qres = zro_q ? 16'd0 : (sat_q ? 16'hFFFF : qr_q);
  assign nmag = (qres > 16'd32767) ? 16'd32767 : qres;

  // per-operation datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_LOAD: begin
        inp_q[0] <= in_item_i.pos_x;
        inp_q[1] <= in_item_i.pos_y;
        inp_q[2] <= in_item_i.pos_z;
        c_q      <= c_cur;
        selc_q   <= s_cur;
        int_q    <= int_d;
        last_q   <= last_d;
      end
      OP_RD1: begin
        lft_q <= new_rd;
        up_q  <= old_rd;
      end
      OP_RD2: begin
        rgt_q <= new_rd;
      end
      OP_RD3: begin
        ctr_q <= new_rd;
      end
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          a_q[k] <= $signed(a_d[k]);
          b_q[k] <= $signed(b_d[k]);
        end
      end
      OP_MUL: begin
        // odd steps keep the first product, even steps from step 2 on close a component
        if (cmd_i.step[0]) begin
          hold_q <= prod_q;
        end else if (cmd_i.step[2:1] != 2'd0) begin
          m_q[ck]   <= cr[63] ? 64'(-cr) : 64'(cr);
          neg_q[ck] <= cr[63];
        end
      end
      OP_MAXC: begin
        mx_q <= (mx01 > m_q[2]) ? mx01 : m_q[2];
      end
      OP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (ge38)      m_q[k] <= m_q[k] >> 8;
          else if (ge30) m_q[k] <= m_q[k] >> 1;
          else if (lt21) m_q[k] <= m_q[k] << 8;
          else           m_q[k] <= m_q[k] << 1;
        end
        if (ge38)      mx_q <= mx_q >> 8;
        else if (ge30) mx_q <= mx_q >> 1;
        else if (lt21) mx_q <= mx_q << 8;
        else if (lt29) mx_q <= mx_q << 1;
      end
      OP_SQ: begin
        // sum of squares builds up in the root's radicand
        if (cmd_i.step[1:0] == 2'd0) begin
          sv_q <= '0;
          sr_q <= '0;
          sb_q <= 64'h4000_0000_0000_0000;
        end else begin
          sv_q <= sv_q + 64'(prod_q);
        end
      end
      OP_SQRT: begin
        if (sv_q >= trial) begin
          sv_q <= sv_q - trial;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_DSET: begin
        dv_q  <= dv_d;
        zro_q <= zro_d;
        sat_q <= num >= {2'b00, dv_d, 16'd0};
        rem_q <= num[46:16];
        qr_q  <= num[15:0];
      end
      OP_DITR: begin
        rem_q <= dge ? 31'(dsh - {1'b0, dv_q}) : dsh[30:0];
        qr_q  <= {qr_q[14:0], dge};
      end
      OP_DSTO: begin
        if (cmd_i.idx < IDX_TEX_U) begin
          res_q[cmd_i.idx] <= neg_q[cmd_i.idx[1:0]] ? (16'd0 - nmag) : nmag;
        end else begin
          res_q[cmd_i.idx] <= qres;
        end
      end
      OP_OUT: begin
        out_item_o.center_x     <= ctr_q[0];
        out_item_o.center_y     <= ctr_q[1];
        out_item_o.center_z     <= ctr_q[2];
        out_item_o.normal_x     <= sts_o.degen ? '0 : res_q[0];
        out_item_o.normal_y     <= sts_o.degen ? '0 : res_q[1];
        out_item_o.normal_z     <= sts_o.degen ? '0 : res_q[2];
        out_item_o.tex_u        <= res_q[3];
        out_item_o.tex_v        <= res_q[4];
        out_item_o.degenerate   <= sts_o.degen;
        out_item_o.last_of_grid <= last_q;
      end
      default: begin
      end
    endcase
  end

  // status to the sequencer
  assign sts_o.interior  = int_q;
  assign sts_o.degen     = (mx_q == '0);
  assign sts_o.norm_done = !ge30 && mx_q[29];

endmodule

`default_nettype wire

// ===== src/heightmap_normal_uv_stream.sv =====
// top level of the heightmap normal/uv stream: register port, sequencer, datapath
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------
//  in      | input     | in_valid_i/in_ready_o | in_item_i (hnu_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_item_o (hnu_out_t)
//  cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// a border vertex only updates the row store and gives no result. an interior vertex
// runs a 32-step square root and five 16-step divisions, the divisions on one shared
// divider; when the cross product is zero only the two texture divisions run.
// reset clears counters and row select; the row stores are not cleared.
// a result waits in the output register while the next item is taken; the
// sequencer stalls only when a new result finds that register still full.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_normal_uv_stream #(
  parameter int unsigned MAX_GRID = hnu_pkg::MAX_GRID_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire hnu_pkg::hnu_in_t                in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output hnu_pkg::hnu_out_t                    out_item_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hnu_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [hnu_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hnu_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import hnu_pkg::*;

  logic [GRID_SIZE_W-1:0] grid_size_q;
  logic [EXTENT_W-1:0]    extent_q;
  logic                   wr_en;
  hnu_cmd_t               cmd;
  hnu_sts_t               sts;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
      extent_q    <= EXTENT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_GRID_SIZE) begin
        grid_size_q <= pwdata[GRID_SIZE_W-1:0];
      end else begin
        extent_q <= pwdata[EXTENT_W-1:0];
      end
    end
  end

  // register readback
  assign prdata = (paddr[2] == REG_EXTENT) ? APB_DATA_W'(extent_q)
                                           : APB_DATA_W'(grid_size_q);

  // sequencer
  hnu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  hnu_datapath #(
    .MAX_GRID (MAX_GRID)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .grid_size_i (grid_size_q),
    .extent_i    (extent_q),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== src/hnu_checker.sv =====
// port checks for the heightmap normal/uv stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hnu_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire hnu_pkg::hnu_out_t out_item_o
);
  import hnu_pkg::*;

  // a result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while another is in work");

  // a new result appears only as the sequencer returns to idle
  a_rise_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised outside the idle return");

endmodule

bind heightmap_normal_uv_stream hnu_checker u_hnu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the heightmap normal/uv stream
`timescale 1ns / 1ps

module testbench;
  import hnu_pkg::*;

  localparam int unsigned ROW_DEPTH = MAX_GRID_DEF;
  localparam int unsigned DIR_ROWS  = 29;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  hnu_in_t in_item;
  logic out_valid;
  logic out_ready;
  hnu_out_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  heightmap_normal_uv_stream u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // shadow state of the normal/uv computation
  logic [95:0] vertex_rows [2][ROW_DEPTH];
  logic        older_sel;
  int unsigned col_cnt;
  int unsigned row_cnt;
  logic [GRID_SIZE_W-1:0] grid_cfg;
  logic [EXTENT_W-1:0]    extent_cfg;

  hnu_out_t pending_results[$];
  int unsigned err_cnt;
  int unsigned result_cnt;
  int unsigned degen_cnt;
  int unsigned item_cnt;
  int unsigned grid_cnt;
  bit calm;
  bit hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("timeout at %0t", $time);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // halve a difference vector when any component reaches 2^31
  function automatic void halve_vec(ref longint v[3]);
    bit big;
    big = 1'b0;
    for (int k = 0; k < 3; k++) if (mag(v[k]) >= (64'd1 << 31)) big = 1'b1;
    if (big) begin
      for (int k = 0; k < 3; k++) v[k] = v[k] < 0 ? -longint'(mag(v[k]) >> 1)
                                                   : longint'(mag(v[k]) >> 1);
    end
  endfunction

  function automatic logic [15:0] tex_of(logic signed [31:0] p, longint e);
    longint t;
    longint unsigned q;
    t = 2 * longint'(p) + e;
    if (t <= 0) return 16'd0;
    q = (longint'(t) * 32768 + e / 2) / e;
    return q > 65535 ? 16'hFFFF : q[15:0];
  endfunction

  // unit normal of cross(a, b) in Q1.15; returns 1 when the cross product is zero
  function automatic bit unit_normal(longint a[3], longint b[3], output logic [15:0] nv[3]);
    longint c[3];
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned len;
    longint unsigned q;
    halve_vec(a);
    halve_vec(b);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = mag(c[k]);
      if (m[k] > mx) mx = m[k];
      nv[k] = 16'd0;
    end
    if (mx == 0) return 1'b1;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) m[k] <<= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] * 32768 + len / 2) / len;
      if (q > 32767) q = 32767;
      nv[k] = c[k] < 0 ? 16'(-q[15:0]) : q[15:0];
    end
    return 1'b0;
  endfunction

  // advance the shadow state by one vertex; returns 1 when a result is due
  function automatic bit predict_vertex(hnu_in_t it, output hnu_out_t o);
    int unsigned n;
    int unsigned c;
    int unsigned r;
    longint e;
    longint a[3];
    longint b[3];
    logic [15:0] nv[3];
    logic [95:0] nl, nr, nc, od;
    bit hit;
    n = grid_cfg < 3 ? 3 : (grid_cfg > ROW_DEPTH ? ROW_DEPTH : grid_cfg);
    e = extent_cfg == 0 ? 1 : longint'(extent_cfg);
    o = '0;
    if (it.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
      older_sel = 1'b0;
    end
    c = col_cnt;
    r = row_cnt;
    hit = r >= 2 && r <= n - 1 && c >= 1 && c <= n - 2;
    if (hit) begin
      nl = vertex_rows[!older_sel][c - 1];
      nr = vertex_rows[!older_sel][c + 1];
      nc = vertex_rows[!older_sel][c];
      od = vertex_rows[older_sel][c];
      for (int k = 0; k < 3; k++) begin
        a[k] = longint'($signed(nr[95 - 32 * k -: 32])) - longint'($signed(nl[95 - 32 * k -: 32]));
        b[k] = longint'($signed(od[95 - 32 * k -: 32]));
      end
      b[0] -= longint'(it.pos_x);
      b[1] -= longint'(it.pos_y);
      b[2] -= longint'(it.pos_z);
      o.degenerate = unit_normal(a, b, nv);
      o.center_x = nc[95:64];
      o.center_y = nc[63:32];
      o.center_z = nc[31:0];
      o.normal_x = nv[0];
      o.normal_y = nv[1];
      o.normal_z = nv[2];
      o.tex_u = tex_of(nc[95:64], e);
      o.tex_v = tex_of(nc[31:0], e);
      o.last_of_grid = r == n - 1 && c == n - 2;
    end
    if (c < ROW_DEPTH) vertex_rows[older_sel][c] = {it.pos_x, it.pos_y, it.pos_z};
    if (c + 1 >= n) begin
      col_cnt = 0;
      older_sel = !older_sel;
      row_cnt = r + 1 >= n ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      if (r >= n) row_cnt = 0;
    end
    return hit;
  endfunction

  // offer one item and record its expected result once taken
  task automatic send_vertex(hnu_in_t it, bit lit, hnu_out_t lit_out);
    hnu_out_t o;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 60);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    item_cnt++;
    if (predict_vertex(it, o)) pending_results = {pending_results, lit ? lit_out : o};
  endtask

  // register write followed by a read back
  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] val);
    @(negedge clk_i);
    in_valid <= 1'b0;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == 3'(REG_GRID_SIZE) << 2) begin
      grid_cfg = val[GRID_SIZE_W-1:0];
      if (prdata[GRID_SIZE_W-1:0] !== grid_cfg) begin
        $display("%0t grid_size read: expected %0d actual %0d", $time, grid_cfg, prdata);
        err_cnt++;
      end
    end else begin
      extent_cfg = val[EXTENT_W-1:0];
      if (prdata[EXTENT_W-1:0] !== extent_cfg) begin
        $display("%0t extent read: expected %0d actual %0d", $time, extent_cfg, prdata);
        err_cnt++;
      end
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // wait for every expected result, then for the block to settle
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // one random grid: 0 smooth terrain, 1 raw random, 2 flat, 3 wide spacing
  task automatic send_grid(int unsigned n, int unsigned mode, bit fs, bit noise);
    hnu_in_t it;
    int signed step;
    logic [31:0] flat;
    step = mode == 3 ? 32'h3000_0000 : int'($urandom_range(32'h40000, 32'h100));
    flat = $urandom;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        it.frame_start = (fs && r == 0 && c == 0) || (noise && $urandom_range(199) == 0);
        case (mode)
          0: begin
            it.pos_x = (c - int'(n) / 2) * step;
            it.pos_z = (r - int'(n) / 2) * step;
            it.pos_y = int'($urandom_range(32'h20000)) - 32'h10000;
          end
          1: begin
            it.pos_x = $urandom;
            it.pos_y = $urandom;
            it.pos_z = $urandom;
          end
          2: begin
            it.pos_x = flat;
            it.pos_y = flat;
            it.pos_z = flat;
          end
          default: begin
            it.pos_x = (c - 1) * step;
            it.pos_z = (r - 1) * step;
            it.pos_y = $urandom;
          end
        endcase
        send_vertex(it, 1'b0, '0);
      end
    end
    grid_cnt++;
  endtask

  // output ready with random gaps and a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int k = 0; k < 600; k++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready <= calm || $urandom_range(99) >= 9;
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_item);
        err_cnt++;
      end else begin
        hnu_out_t w;
        w = pending_results.pop_front();
        result_cnt++;
        if (w.degenerate) degen_cnt++;
        if (w.center_x !== out_item.center_x || w.center_y !== out_item.center_y ||
            w.center_z !== out_item.center_z) begin
          $display("%0t center: expected %h %h %h actual %h %h %h", $time, w.center_x,
                   w.center_y, w.center_z, out_item.center_x, out_item.center_y,
                   out_item.center_z);
          err_cnt++;
        end
        if (w.normal_x !== out_item.normal_x || w.normal_y !== out_item.normal_y ||
            w.normal_z !== out_item.normal_z) begin
          $display("%0t normal: expected %h %h %h actual %h %h %h", $time, w.normal_x,
                   w.normal_y, w.normal_z, out_item.normal_x, out_item.normal_y,
                   out_item.normal_z);
          err_cnt++;
        end
        if (w.tex_u !== out_item.tex_u || w.tex_v !== out_item.tex_v) begin
          $display("%0t tex: expected %h %h actual %h %h", $time, w.tex_u, w.tex_v,
                   out_item.tex_u, out_item.tex_v);
          err_cnt++;
        end
        if (w.degenerate !== out_item.degenerate || w.last_of_grid !== out_item.last_of_grid) begin
          $display("%0t flags degenerate/last: expected %b %b actual %b %b", $time,
                   w.degenerate, w.last_of_grid, out_item.degenerate, out_item.last_of_grid);
          err_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    hnu_in_t  dir_item [DIR_ROWS];
    bit       dir_lit  [DIR_ROWS];
    hnu_out_t dir_want [DIR_ROWS];
    logic [31:0] edge_vals [5];
    int unsigned rand_items;
    int unsigned n;

    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    err_cnt = 0; result_cnt = 0; degen_cnt = 0; item_cnt = 0; grid_cnt = 0;
    calm = 1'b0; hold_req = 1'b0;
    older_sel = 1'b0; col_cnt = 0; row_cnt = 0;
    grid_cfg = GRID_SIZE_RST;
    extent_cfg = EXTENT_RST;
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};

    // directed rows: flat zero grid, extreme grid, broken start, then a clean grid
    for (int k = 0; k < DIR_ROWS; k++) begin
      dir_item[k] = '0;
      dir_lit[k] = 1'b0;
      dir_want[k] = '0;
    end
    dir_item[0].frame_start = 1'b1;
    dir_lit[7] = 1'b1;
    dir_want[7].tex_u = 16'h8000;
    dir_want[7].tex_v = 16'h8000;
    dir_want[7].degenerate = 1'b1;
    dir_want[7].last_of_grid = 1'b1;
    for (int k = 9; k < 18; k++) begin
      dir_item[k].frame_start = k == 9;
      dir_item[k].pos_x = edge_vals[k % 5];
      dir_item[k].pos_y = edge_vals[(k * 3) % 5];
      dir_item[k].pos_z = edge_vals[(k * 2 + 1) % 5];
    end
    dir_item[18] = {1'b1, 32'h1234, 32'h5678, 32'h9ABC};
    dir_item[19] = {1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    for (int k = 20; k < DIR_ROWS; k++) begin
      dir_item[k].frame_start = k == 20;
      dir_item[k].pos_x = ((k - 20) % 3) * 32'h10000;
      dir_item[k].pos_z = ((k - 20) / 3) * 32'h10000;
      dir_item[k].pos_y = k == 24 ? 32'h8000 : 32'h0;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(3'(REG_GRID_SIZE) << 2, 32'd3);
    for (int k = 0; k < DIR_ROWS; k++) send_vertex(dir_item[k], dir_lit[k], dir_want[k]);
    drain();

    // random phases over several register settings
    rand_items = 0;
    for (int ph = 0; rand_items < 1200; ph++) begin
      case (ph % 6)
        0: n = 0;
        1: n = 2;
        2: n = 3;
        default: n = $urandom_range(10, 3);
      endcase
      write_reg(3'(REG_GRID_SIZE) << 2, n);
      case (ph % 5)
        0: write_reg(3'(REG_EXTENT) << 2, 32'd0);
        1: write_reg(3'(REG_EXTENT) << 2, 32'h7FFF_FFFF);
        2: write_reg(3'(REG_EXTENT) << 2, 32'd1);
        default: write_reg(3'(REG_EXTENT) << 2, $urandom_range(32'h7FFF_FFFF, 1));
      endcase
      calm = ph == 3;
      if (ph == 2) hold_req = 1'b1;
      n = grid_cfg < 3 ? 3 : grid_cfg;
      for (int g = 0; g < 4; g++) begin
        send_grid(n, $urandom_range(99) < 55 ? 0 : $urandom_range(3, 1), g == 0 || g == 2,
                  g == 3);
        rand_items += n * n;
      end
      drain();

      // one short pass at an oversize setting: part of a border row only
      if (ph == 4) begin
        write_reg(3'(REG_GRID_SIZE) << 2, 32'd2047);
        for (int k = 0; k < 64; k++) begin
          hnu_in_t it;
          it.frame_start = k == 0;
          it.pos_x = k * 32'h100;
          it.pos_z = 32'h0;
          it.pos_y = $urandom_range(32'hFFF);
          send_vertex(it, 1'b0, '0);
        end
        drain();
      end
    end
    calm = 1'b0;

    $display("%0d vertices in %0d grids, %0d results checked, %0d of them degenerate",
             item_cnt, grid_cnt, result_cnt, degen_cnt);
    $display("grid sizes 0..10 and an oversize setting, extent 0..2^31-1, long output stall");
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hnu_pkg.sv
src/hnu_ctrl.sv
src/hnu_datapath.sv
src/heightmap_normal_uv_stream.sv
src/hnu_checker.sv
tb/sv/testbench.sv
